>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Assumes clk_i and rst_ni exist in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define QRCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define QRCI_ASSERT_NEVER(lbl, cond, msg) \
  `QRCI_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/qrci_pkg.sv
// Types and constants for the QR codeword interleaver.
// No dependencies; imported by every module of the block.
package qrci_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BLK_W       = 8;
  localparam int unsigned COL_W       = 8;
  localparam int unsigned OFS_W       = 17;
  localparam int unsigned CALC_W      = 17;
  localparam int unsigned BASE_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_AW      = 5;
  localparam int unsigned CFG_DW      = 32;

  localparam logic [2:0] REG_BLOCKS_GROUP1   = 3'd0;
  localparam logic [2:0] REG_DATA_PER_BLOCK1 = 3'd1;
  localparam logic [2:0] REG_BLOCKS_GROUP2   = 3'd2;
  localparam logic [2:0] REG_DATA_PER_BLOCK2 = 3'd3;
  localparam logic [2:0] REG_EC_PER_BLOCK    = 3'd4;

  typedef enum logic [1:0] {
    CMD_LOAD_DATA = 2'd0,
    CMD_LOAD_EC   = 2'd1,
    CMD_EMIT      = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_TAIL = 2'd1,
    PH_EC   = 2'd2,
    PH_REM  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_REM   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BASE_ZERO = 2'd0,
    BASE_B1   = 2'd1,
    BASE_D    = 2'd2
  } base_e;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_DPB1 = 2'd1,
    MUL_DPB2 = 2'd2,
    MUL_EPB  = 2'd3
  } mul_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] codeword_in;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [6:0] blocks_group1;
    logic [7:0] data_per_block1;
    logic [6:0] blocks_group2;
    logic [7:0] data_per_block2;
    logic [7:0] ec_per_block;
  } cfg_t;

  // One store access, as classified by the front end
  typedef struct packed {
    op_e               op;
    base_e             base;
    mul_e              mul;
    logic [BLK_W-1:0]  mblk;
    logic [OFS_W-1:0]  offset;
    logic [BYTE_W-1:0] data;
  } entry_t;

endpackage

>>> rtl/core/qrci_queue.sv
// Small FIFO of store accesses between front and back end.
// Depends on qrci_pkg.
module qrci_queue import qrci_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/qrci_front.sv
// Front end: accepts commands, keeps fill and emit counters, and queues
// at most one classified store access per accepted beat. Depends on qrci_pkg.
module qrci_front import qrci_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   start_i,
  input  item_t  item_i,
  input  logic   q_full_i,
  output logic   busy_o,
  output logic   push_o,
  output entry_t entry_o
);

  localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);

  logic [FILL_W-1:0] dfill_q, dfill_d;
  logic [FILL_W-1:0] efill_q, efill_d;
  phase_e            phase_q, phase_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [BLK_W-1:0]  blk_q, blk_d;

  logic              accept;
  logic [BLK_W-1:0]  nb;
  phase_e            rph;
  logic [COL_W-1:0]  rcol;
  logic [BLK_W-1:0]  rblk;
  logic [BLK_W:0]    blk_inc;
  logic [BLK_W:0]    blk_lim;

  assign busy_o = q_full_i;
  assign accept = start_i && !q_full_i;
  assign nb     = {1'b0, cfg_i.blocks_group1} + {1'b0, cfg_i.blocks_group2};

  // Skip empty phases: at most three transitions reach the remainder byte
  always_comb begin
    logic ok;
    rph  = phase_q;
    rcol = col_q;
    rblk = blk_q;
    for (int i = 0; i < 3; i++) begin
      case (rph)
        PH_DATA: ok = (rcol < cfg_i.data_per_block1) && (rblk < nb);
        PH_TAIL: ok = (rcol < cfg_i.data_per_block2) && (rblk < {1'b0, cfg_i.blocks_group2});
        PH_EC:   ok = (rcol < cfg_i.ec_per_block) && (rblk < nb);
        default: ok = 1'b1;
      endcase
      if (!ok) begin
        case (rph)
          PH_DATA: begin
            rph  = PH_TAIL;
            rcol = cfg_i.data_per_block1;
          end
          PH_TAIL: begin
            rph  = PH_EC;
            rcol = '0;
          end
          default: begin
            rph  = PH_REM;
            rcol = '0;
          end
        endcase
        rblk = '0;
      end
    end
  end

  assign blk_inc = {1'b0, rblk} + 1'b1;
  assign blk_lim = (rph == PH_TAIL) ? {2'b0, cfg_i.blocks_group2} : {1'b0, nb};

  always_comb begin
    dfill_d = dfill_q;
    efill_d = efill_q;
    phase_d = phase_q;
    col_d   = col_q;
    blk_d   = blk_q;
    push_o  = 1'b0;
    entry_o = '{op: OP_WRITE, base: BASE_ZERO, mul: MUL_NONE, mblk: '0,
                offset: '0, data: item_i.codeword_in};
    if (accept) begin
      case (item_i.cmd)
        CMD_LOAD_DATA: begin
          if (dfill_q < FILL_W'(STORE_DEPTH)) begin
            push_o         = 1'b1;
            entry_o.offset = OFS_W'(dfill_q);
            dfill_d        = dfill_q + 1'b1;
          end
        end
        CMD_LOAD_EC: begin
          push_o         = 1'b1;
          entry_o.base   = BASE_D;
          entry_o.offset = OFS_W'(efill_q);
          if (efill_q < FILL_W'(STORE_DEPTH)) begin
            efill_d = efill_q + 1'b1;
          end
        end
        CMD_EMIT: begin
          push_o = 1'b1;
          if (rph == PH_REM) begin
            entry_o.op = OP_REM;
            dfill_d    = '0;
            efill_d    = '0;
            phase_d    = PH_DATA;
            col_d      = '0;
            blk_d      = '0;
          end else begin
            entry_o.op     = OP_READ;
            entry_o.offset = OFS_W'(rcol);
            entry_o.mblk   = rblk;
            case (rph)
              PH_DATA: begin
                if (rblk < {1'b0, cfg_i.blocks_group1}) begin
                  entry_o.mul = MUL_DPB1;
                end else begin
                  entry_o.base = BASE_B1;
                  entry_o.mul  = MUL_DPB2;
                  entry_o.mblk = rblk - {1'b0, cfg_i.blocks_group1};
                end
              end
              PH_TAIL: begin
                entry_o.base = BASE_B1;
                entry_o.mul  = MUL_DPB2;
              end
              default: begin
                entry_o.base = BASE_D;
                entry_o.mul  = MUL_EPB;
              end
            endcase
            phase_d = rph;
            if (blk_inc >= blk_lim) begin
              blk_d = '0;
              col_d = rcol + 1'b1;
            end else begin
              blk_d = blk_inc[BLK_W-1:0];
              col_d = rcol;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfill_q <= '0;
      efill_q <= '0;
      phase_q <= PH_DATA;
      col_q   <= '0;
      blk_q   <= '0;
    end else begin
      dfill_q <= dfill_d;
      efill_q <= efill_d;
      phase_q <= phase_d;
      col_q   <= col_d;
      blk_q   <= blk_d;
    end
  end

endmodule

>>> rtl/core/qrci_back.sv
// Back end: address arithmetic, codeword store and result register.
// Depends on qrci_pkg.
module qrci_back import qrci_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_empty_i,
  input  entry_t  head_i,
  output logic    pop_o,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic [BYTE_W-1:0] store_q [STORE_DEPTH];

  logic [14:0]        b1_q, d2_q;
  logic [BASE_W-1:0]  base;
  logic [7:0]         mult;

  logic               a_valid_q;
  op_e                a_op_q;
  logic [BYTE_W-1:0]  a_data_q;
  logic [CALC_W-1:0]  a_sum_q;
  logic [15:0]        a_prod_q;

  logic               b_valid_q;
  op_e                b_op_q;
  logic [BYTE_W-1:0]  b_data_q;
  logic [CALC_W-1:0]  b_addr_q;
  logic               b_hit;

  logic               c_valid_q;
  op_e                c_op_q;
  logic               c_hit_q;
  logic [BYTE_W-1:0]  rd_q;

  assign pop_o = !q_empty_i;

  always_comb begin
    case (head_i.base)
      BASE_B1: base = BASE_W'(b1_q);
      BASE_D:  base = BASE_W'(b1_q) + BASE_W'(d2_q);
      default: base = '0;
    endcase
    case (head_i.mul)
      MUL_DPB1: mult = cfg_i.data_per_block1;
      MUL_DPB2: mult = cfg_i.data_per_block2;
      MUL_EPB:  mult = cfg_i.ec_per_block;
      default:  mult = '0;
    endcase
  end

  assign b_hit = (b_addr_q < CALC_W'(STORE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= pop_o;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q     <= cfg_i.blocks_group1 * cfg_i.data_per_block1;
    d2_q     <= cfg_i.blocks_group2 * cfg_i.data_per_block2;
    a_op_q   <= head_i.op;
    a_data_q <= head_i.data;
    a_prod_q <= head_i.mblk * mult;
    a_sum_q  <= CALC_W'(base) + CALC_W'(head_i.offset);
    b_op_q   <= a_op_q;
    b_data_q <= a_data_q;
    b_addr_q <= a_sum_q + CALC_W'(a_prod_q);
    c_op_q   <= b_op_q;
    c_hit_q  <= b_hit;
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && b_op_q == OP_WRITE && b_hit) begin
      store_q[b_addr_q[AW-1:0]] <= b_data_q;
    end
    rd_q <= store_q[b_addr_q[AW-1:0]];
  end

  assign result_valid_o    = c_valid_q && (c_op_q == OP_READ || c_op_q == OP_REM);
  assign result_o.last     = (c_op_q == OP_REM);
  assign result_o.out_byte = (c_op_q == OP_READ && c_hit_q) ? rd_q : '0;

endmodule

>>> rtl/core/qr_codeword_interleaver.sv
// QR codeword interleaver: one command beat per cycle, busy_o stays low in use.
// An emit's result passes through the queue, address add/multiply, address sum
// and store read registers; loads give no result.
// Reset clears counters and queue, sets registers to their defaults;
// the store is not cleared. The receiver cannot stall results.
module qr_codeword_interleaver import qrci_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  item_t             item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg_q;
  logic   q_full, q_empty, push, pop;
  entry_t entry, head;
  logic   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blocks_group1   <= 7'd1;
      cfg_q.data_per_block1 <= 8'd19;
      cfg_q.blocks_group2   <= 7'd0;
      cfg_q.data_per_block2 <= 8'd0;
      cfg_q.ec_per_block    <= 8'd7;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_BLOCKS_GROUP1:   cfg_q.blocks_group1   <= pwdata[6:0];
        REG_DATA_PER_BLOCK1: cfg_q.data_per_block1 <= pwdata[7:0];
        REG_BLOCKS_GROUP2:   cfg_q.blocks_group2   <= pwdata[6:0];
        REG_DATA_PER_BLOCK2: cfg_q.data_per_block2 <= pwdata[7:0];
        REG_EC_PER_BLOCK:    cfg_q.ec_per_block    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BLOCKS_GROUP1:   prdata = CFG_DW'(cfg_q.blocks_group1);
      REG_DATA_PER_BLOCK1: prdata = CFG_DW'(cfg_q.data_per_block1);
      REG_BLOCKS_GROUP2:   prdata = CFG_DW'(cfg_q.blocks_group2);
      REG_DATA_PER_BLOCK2: prdata = CFG_DW'(cfg_q.data_per_block2);
      REG_EC_PER_BLOCK:    prdata = CFG_DW'(cfg_q.ec_per_block);
      default:             prdata = '0;
    endcase
  end

  qrci_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .start_i  (start_i),
    .item_i   (item_i),
    .q_full_i (q_full),
    .busy_o   (busy_o),
    .push_o   (push),
    .entry_o  (entry)
  );

  qrci_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  qrci_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

>>> rtl/core/qrci_checker.sv
// Port-level checks for the QR codeword interleaver, bound to the top level.
// Depends on qrci_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qrci_checker import qrci_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input item_t   item_i,
  input logic    busy_o,
  input logic    result_valid_o,
  input result_t result_o
);

  logic emit_beat;

  assign emit_beat = start_i && !busy_o && (item_i.cmd == CMD_EMIT);

  `QRCI_ASSERT(a_emit_gives_result, emit_beat |-> ##4 result_valid_o, "emit without result")
  `QRCI_ASSERT(a_result_from_emit, result_valid_o |-> $past(emit_beat, 4), "result without emit")
  `QRCI_ASSERT_NEVER(a_last_is_zero, result_valid_o && result_o.last && result_o.out_byte != '0, "nonzero remainder byte")

endmodule

bind qr_codeword_interleaver qrci_checker u_qrci_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .item_i         (item_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
